// File: design/response_token_matcher_with_capture_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the response token matcher
// Concurrent property helpers included by the asserting design file of the block.
// ---------------------------------------------------------------------------
`ifndef RESPONSE_TOKEN_MATCHER_WITH_CAPTURE_UNIT_ASSERT_SVH
`define RESPONSE_TOKEN_MATCHER_WITH_CAPTURE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rtm assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define RTM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rtm assertion failed: next-cycle implication");

`endif

// File: design/rtm_pkg.sv
// ---------------------------------------------------------------------------
// Response token matcher package
// Sequencer states, item and result codes, register indexes and constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtm_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REPLAY,
        ST_TAIL
    } state_t;

    // input item kinds (tuser)
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // result kinds (tuser)
    localparam logic [1:0] RES_CAPTURE = 2'd0;
    localparam logic [1:0] RES_FOUND   = 2'd1;
    localparam logic [1:0] RES_TIMEOUT = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_TOKEN_LENGTH  = 3'd0;
    localparam logic [2:0] REG_CHARS_LOW     = 3'd1;
    localparam logic [2:0] REG_CHARS_MID     = 3'd2;
    localparam logic [2:0] REG_CHARS_HIGH    = 3'd3;
    localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd4;
    localparam logic [2:0] REG_ALWAYS_SKIP   = 3'd5;

    localparam int unsigned TOKEN_SLOTS   = 24;
    localparam int unsigned TOK_IDX_W     = 5;
    localparam int unsigned CAPTURE_LIMIT = 20;

    localparam logic [7:0]  CHAR_CR = 8'h0D;
    localparam logic [7:0]  CHAR_LF = 8'h0A;
    localparam logic [15:0] TICKS_MAX = 16'hFFFF;

endpackage

// File: design/response_token_matcher_with_capture_unit.sv
// ---------------------------------------------------------------------------
// Response token matcher with capture
// Watches received serial bytes for a reply token and replays mismatches.
// ---------------------------------------------------------------------------
// The block takes one transaction at a time on the s_ side and gives its
// results on the m_ side: a token found result, a timed out result, or, on a
// mismatch, the matched prefix (at most 20 characters) followed by the
// offending byte as captured bytes, with m_tlast on the final result of each
// input. A start, ignored or skipped item passes ST_IDLE and ST_CHECK, a
// matching byte or a tick the same plus any wait on m_tready, and a mismatch
// then ST_REPLAY for any prefix and ST_TAIL for the offending byte. The
// single shared token character selector serves the compare and then each
// replayed character, one per cycle while m_tready allows. A finished result
// sits in the output register while the sequencer goes on to the next step.
// Configuration writes are taken at any time but belong only to idle periods.
`timescale 1ns / 1ps

module response_token_matcher_with_capture_unit #(
    parameter int unsigned MAX_TOKEN_CHARS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input transactions
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic [1:0]  s_tuser,    // [1:0] kind
    // result transactions
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] captured_byte
    output logic [1:0]  m_tuser,    // [1:0] result_kind
    output logic        m_tlast,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int unsigned MP_W = $clog2(MAX_TOKEN_CHARS + 1);
    localparam int unsigned TW   = rtm_pkg::TOK_IDX_W;

    // configuration registers
    logic [4:0]  token_length_reg;
    logic [63:0] chars_low_reg;
    logic [63:0] chars_mid_reg;
    logic [63:0] chars_high_reg;
    logic [15:0] timeout_ticks_reg;
    logic        always_skip_reg;

    // search state
    rtm_pkg::state_t state_reg, state_next;
    logic [MP_W-1:0] match_pos_reg, match_pos_next;
    logic            seen_first_reg, seen_first_next;
    logic            search_done_reg, search_done_next;
    logic [15:0]     elapsed_reg, elapsed_next;

    // held item and replay counters
    logic [1:0]      kind_reg, kind_next;
    logic [7:0]      byte_reg, byte_next;
    logic [TW-1:0]   rep_idx_reg, rep_idx_next;
    logic [TW-1:0]   rep_cnt_reg, rep_cnt_next;

    // output register
    logic            m_valid_reg, m_valid_next;
    logic [1:0]      m_kind_reg, m_kind_next;
    logic [7:0]      m_byte_reg, m_byte_next;
    logic            m_last_reg, m_last_next;

    // shared token character selector
    logic [7:0]      tok_chars [rtm_pkg::TOKEN_SLOTS];
    logic [TW-1:0]   sel_idx;
    logic [7:0]      sel_char;

    logic            out_free;
    logic [4:0]      eff_len;
    logic [MP_W-1:0] pos;
    logic [5:0]      pos_plus;
    logic [15:0]     ticks_inc;
    logic            is_break;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == rtm_pkg::ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = m_kind_reg;
    assign m_tdata   = m_byte_reg;
    assign m_tlast   = m_last_reg;

    // Lay the three character words out as one row of token slots.
    for (genvar g = 0; g < 8; g++) begin : g_slots
        assign tok_chars[g]      = chars_low_reg[8*g +: 8];
        assign tok_chars[g + 8]  = chars_mid_reg[8*g +: 8];
        assign tok_chars[g + 16] = chars_high_reg[8*g +: 8];
    end

    assign sel_char = tok_chars[sel_idx];

    // Clamp the programmed length into 1 .. MAX_TOKEN_CHARS.
    always_comb begin
        if (token_length_reg == 5'd0) begin
            eff_len = 5'd1;
        end else if (token_length_reg > 5'(MAX_TOKEN_CHARS)) begin
            eff_len = 5'(MAX_TOKEN_CHARS);
        end else begin
            eff_len = token_length_reg;
        end
    end

    assign out_free  = !m_valid_reg || m_tready;
    assign pos       = (match_pos_reg >= MP_W'(MAX_TOKEN_CHARS)) ? '0 : match_pos_reg;
    assign pos_plus  = 6'(pos) + 6'd1;
    assign ticks_inc = (elapsed_reg == rtm_pkg::TICKS_MAX) ? elapsed_reg : elapsed_reg + 16'd1;
    assign is_break  = (byte_reg == rtm_pkg::CHAR_CR) || (byte_reg == rtm_pkg::CHAR_LF);

    // Configuration write channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_length_reg  <= 5'd2;
            chars_low_reg     <= 64'd19279;
            chars_mid_reg     <= 64'd0;
            chars_high_reg    <= 64'd0;
            timeout_ticks_reg <= 16'd5000;
            always_skip_reg   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rtm_pkg::REG_TOKEN_LENGTH:  token_length_reg  <= cfg_data[4:0];
                rtm_pkg::REG_CHARS_LOW:     chars_low_reg     <= cfg_data;
                rtm_pkg::REG_CHARS_MID:     chars_mid_reg     <= cfg_data;
                rtm_pkg::REG_CHARS_HIGH:    chars_high_reg    <= cfg_data;
                rtm_pkg::REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[15:0];
                rtm_pkg::REG_ALWAYS_SKIP:   always_skip_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= rtm_pkg::ST_IDLE;
            match_pos_reg   <= '0;
            seen_first_reg  <= 1'b0;
            search_done_reg <= 1'b1;
            elapsed_reg     <= 16'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            match_pos_reg   <= match_pos_next;
            seen_first_reg  <= seen_first_next;
            search_done_reg <= search_done_next;
            elapsed_reg     <= elapsed_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        byte_reg    <= byte_next;
        rep_idx_reg <= rep_idx_next;
        rep_cnt_reg <= rep_cnt_next;
        m_kind_reg  <= m_kind_next;
        m_byte_reg  <= m_byte_next;
        m_last_reg  <= m_last_next;
    end

    // Sequencer: next state, search updates and result loading.
    always_comb begin
        state_next       = state_reg;
        match_pos_next   = match_pos_reg;
        seen_first_next  = seen_first_reg;
        search_done_next = search_done_reg;
        elapsed_next     = elapsed_reg;
        kind_next        = kind_reg;
        byte_next        = byte_reg;
        rep_idx_next     = rep_idx_reg;
        rep_cnt_next     = rep_cnt_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_kind_next      = m_kind_reg;
        m_byte_next      = m_byte_reg;
        m_last_next      = m_last_reg;
        sel_idx          = TW'(pos);

        case (state_reg)
            rtm_pkg::ST_IDLE: begin
                // capture the transaction for evaluation
                if (s_tvalid) begin
                    kind_next  = s_tuser;
                    byte_next  = s_tdata;
                    state_next = rtm_pkg::ST_CHECK;
                end
            end
            rtm_pkg::ST_CHECK: begin
                state_next = rtm_pkg::ST_IDLE;
                if (kind_reg == rtm_pkg::KIND_START) begin
                    match_pos_next   = '0;
                    seen_first_next  = 1'b0;
                    search_done_next = 1'b0;
                    elapsed_next     = 16'd0;
                end else if (search_done_reg ||
                             (kind_reg != rtm_pkg::KIND_BYTE &&
                              kind_reg != rtm_pkg::KIND_TICK)) begin
                    // drop: idle search or unknown kind
                end else if (kind_reg == rtm_pkg::KIND_TICK) begin
                    if (ticks_inc >= timeout_ticks_reg) begin
                        // hold until the output register frees up
                        if (out_free) begin
                            elapsed_next     = ticks_inc;
                            search_done_next = 1'b1;
                            m_valid_next     = 1'b1;
                            m_kind_next      = rtm_pkg::RES_TIMEOUT;
                            m_byte_next      = 8'd0;
                            m_last_next      = 1'b1;
                        end else begin
                            state_next = rtm_pkg::ST_CHECK;
                        end
                    end else begin
                        elapsed_next = ticks_inc;
                    end
                end else if (elapsed_reg >= timeout_ticks_reg) begin
                    // time ran out before this byte
                    if (out_free) begin
                        search_done_next = 1'b1;
                        m_valid_next     = 1'b1;
                        m_kind_next      = rtm_pkg::RES_TIMEOUT;
                        m_byte_next      = 8'd0;
                        m_last_next      = 1'b1;
                    end else begin
                        state_next = rtm_pkg::ST_CHECK;
                    end
                end else if (is_break && (always_skip_reg || !seen_first_reg)) begin
                    // skip line break
                end else if (byte_reg == sel_char) begin
                    if (pos_plus >= 6'(eff_len)) begin
                        if (out_free) begin
                            seen_first_next  = 1'b1;
                            match_pos_next   = '0;
                            search_done_next = 1'b1;
                            m_valid_next     = 1'b1;
                            m_kind_next      = rtm_pkg::RES_FOUND;
                            m_byte_next      = 8'd0;
                            m_last_next      = 1'b1;
                        end else begin
                            state_next = rtm_pkg::ST_CHECK;
                        end
                    end else begin
                        seen_first_next = 1'b1;
                        match_pos_next  = MP_W'(pos_plus);
                    end
                end else begin
                    // mismatch: replay the prefix, then the offending byte
                    seen_first_next = 1'b1;
                    match_pos_next  = '0;
                    rep_idx_next    = '0;
                    if (TW'(pos) > TW'(rtm_pkg::CAPTURE_LIMIT)) begin
                        rep_cnt_next = TW'(rtm_pkg::CAPTURE_LIMIT);
                    end else begin
                        rep_cnt_next = TW'(pos);
                    end
                    state_next = (pos == '0) ? rtm_pkg::ST_TAIL : rtm_pkg::ST_REPLAY;
                end
            end
            rtm_pkg::ST_REPLAY: begin
                sel_idx = rep_idx_reg;
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = rtm_pkg::RES_CAPTURE;
                    m_byte_next  = sel_char;
                    m_last_next  = 1'b0;
                    rep_idx_next = rep_idx_reg + TW'(1);
                    if (rep_idx_reg + TW'(1) == rep_cnt_reg) begin
                        state_next = rtm_pkg::ST_TAIL;
                    end
                end
            end
            rtm_pkg::ST_TAIL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = rtm_pkg::RES_CAPTURE;
                    m_byte_next  = byte_reg;
                    m_last_next  = 1'b1;
                    state_next   = rtm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rtm_pkg::ST_IDLE;
            end
        endcase
    end

    // Assertions
    `include "response_token_matcher_with_capture_unit_assert.svh"

    `RTM_ASSERT_IMP(a_replay_in_range, aclk, aresetn, state_reg == rtm_pkg::ST_REPLAY, rep_idx_reg < rep_cnt_reg)
    `RTM_ASSERT_NXT(a_accept_to_check, aclk, aresetn, s_tvalid && s_tready, state_reg == rtm_pkg::ST_CHECK)
    `RTM_ASSERT_IMP(a_found_is_last, aclk, aresetn, m_valid_reg && m_kind_reg != rtm_pkg::RES_CAPTURE, m_last_reg && m_byte_reg == 8'd0)
    `RTM_ASSERT_NXT(a_result_held, aclk, aresetn, m_valid_reg && !m_tready, m_valid_reg && $stable({m_kind_reg, m_byte_reg, m_last_reg}))

endmodule

// File: tb/sv/response_token_matcher_with_capture_unit_checker.sv
// ---------------------------------------------------------------------------
// Result checker for the response token matcher
// Watches the input, result and configuration channels, keeps its own copy
// of the search state and compares every result transaction with the oldest
// predicted one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module response_token_matcher_with_capture_unit_checker
    import rtm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int unsigned error_count,
    output int unsigned pending,
    output int unsigned items_seen,
    output int unsigned found_seen,
    output int unsigned timeout_seen,
    output int unsigned capture_seen
);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       is_last;
    } search_result_t;

    search_result_t awaited_results[$];

    // register copies
    logic [4:0]  token_len;
    logic [63:0] token_words[3];
    logic [15:0] timeout_limit;
    logic        skip_always;

    // search state
    logic [4:0]  match_pos;
    logic        seen_first;
    logic        search_idle;
    logic [15:0] elapsed;

    function automatic logic [7:0] token_byte(input int unsigned idx);
        logic [191:0] all_chars;
        all_chars = {token_words[2], token_words[1], token_words[0]};
        return all_chars[idx*8 +: 8];
    endfunction

    function automatic int unsigned token_span();
        if (token_len == 5'd0) return 1;
        if (token_len > TOKEN_SLOTS) return TOKEN_SLOTS;
        return token_len;
    endfunction

    // Advance the search by one accepted input and queue what it produces.
    task automatic step_token_search(input logic [1:0] kind, input logic [7:0] rx);
        search_result_t produced[$];
        int unsigned    replay;
        int unsigned    i;
        if (kind == KIND_START) begin
            match_pos   = '0;
            seen_first  = 1'b0;
            search_idle = 1'b0;
            elapsed     = '0;
            items_seen++;
            return;
        end
        if ((kind != KIND_BYTE && kind != KIND_TICK) || search_idle) return;
        if (kind == KIND_TICK) begin
            items_seen++;
            if (elapsed != TICKS_MAX) elapsed++;
            if (elapsed >= timeout_limit) begin
                search_idle = 1'b1;
                produced.push_back('{RES_TIMEOUT, 8'h00, 1'b0});
            end
        end else if (elapsed >= timeout_limit) begin
            // time already ran out: the byte is not looked at
            items_seen++;
            search_idle = 1'b1;
            produced.push_back('{RES_TIMEOUT, 8'h00, 1'b0});
        end else begin
            if ((rx == CHAR_CR || rx == CHAR_LF) && (skip_always || !seen_first)) return;
            items_seen++;
            seen_first = 1'b1;
            if (match_pos >= TOKEN_SLOTS) match_pos = '0;
            if (rx == token_byte(match_pos)) begin
                match_pos++;
                if (match_pos >= token_span()) begin
                    match_pos   = '0;
                    search_idle = 1'b1;
                    produced.push_back('{RES_FOUND, 8'h00, 1'b0});
                end
            end else begin
                replay = (match_pos < CAPTURE_LIMIT) ? match_pos : CAPTURE_LIMIT;
                for (i = 0; i < replay; i++)
                    produced.push_back('{RES_CAPTURE, token_byte(i), 1'b0});
                produced.push_back('{RES_CAPTURE, rx, 1'b0});
                match_pos = '0;
            end
        end
        if (produced.size() != 0) produced[produced.size()-1].is_last = 1'b1;
        foreach (produced[k]) awaited_results.push_back(produced[k]);
    endtask

    always @(posedge aclk) begin : watch
        search_result_t oldest;
        if (!aresetn) begin
            token_len      = 5'd2;
            token_words[0] = 64'h4B4F;
            token_words[1] = '0;
            token_words[2] = '0;
            timeout_limit  = 16'd5000;
            skip_always    = 1'b0;
            match_pos      = '0;
            seen_first     = 1'b0;
            search_idle    = 1'b1;
            elapsed        = '0;
            error_count    = 0;
            items_seen     = 0;
            found_seen     = 0;
            timeout_seen   = 0;
            capture_seen   = 0;
            awaited_results.delete();
        end else begin
            // compare first: a result never stems from an input of the same edge
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    error_count++;
                    $error("unexpected result: result_kind %0d, captured_byte %02h",
                           m_tuser, m_tdata);
                end else begin
                    oldest = awaited_results.pop_front();
                    if (m_tuser !== oldest.kind) begin
                        error_count++;
                        $error("result_kind: expected %0d, actual %0d", oldest.kind, m_tuser);
                    end
                    if (m_tdata !== oldest.data) begin
                        error_count++;
                        $error("captured_byte: expected %02h, actual %02h",
                               oldest.data, m_tdata);
                    end
                    if (m_tlast !== oldest.is_last) begin
                        error_count++;
                        $error("last: expected %0d, actual %0d", oldest.is_last, m_tlast);
                    end
                    case (oldest.kind)
                        RES_FOUND:   found_seen++;
                        RES_TIMEOUT: timeout_seen++;
                        default:     capture_seen++;
                    endcase
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TOKEN_LENGTH:  token_len      = cfg_data[4:0];
                    REG_CHARS_LOW:     token_words[0] = cfg_data;
                    REG_CHARS_MID:     token_words[1] = cfg_data;
                    REG_CHARS_HIGH:    token_words[2] = cfg_data;
                    REG_TIMEOUT_TICKS: timeout_limit  = cfg_data[15:0];
                    REG_ALWAYS_SKIP:   skip_always    = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) step_token_search(s_tuser, s_tdata);
        end
        pending = awaited_results.size();
    end

endmodule

// File: tb/sv/response_token_matcher_with_capture_unit_tb.sv
// ---------------------------------------------------------------------------
// Testbench for the response token matcher with capture
// Drives start, byte and tick transactions through several register
// settings, with random gaps and stalls on both channels, and leaves all
// checking to the result checker beside the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module response_token_matcher_with_capture_unit_tb;

    // codes the package leaves unnamed
    localparam logic [1:0] KIND_SPARE   = 2'd3;
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam logic [7:0] CHAR_O = 8'h4F;
    localparam logic [7:0] CHAR_K = 8'h4B;

    localparam int unsigned TARGET_ITEMS   = 250;
    localparam int unsigned SETTLE_CYCLES  = 30;
    localparam int unsigned HOLD_CYCLES    = 200;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] data_byte
    logic [1:0]  s_tuser;    // [1:0] kind
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [7:0] captured_byte
    logic [1:0]  m_tuser;    // [1:0] result_kind
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    int unsigned error_count;
    int unsigned pending;
    int unsigned items_seen;
    int unsigned found_seen;
    int unsigned timeout_seen;
    int unsigned capture_seen;

    // every input transaction taken by the block, acted on or not
    int unsigned sent_count = 0;

    // stimulus-side copy of the token, used only to build plausible replies
    logic [4:0]  tok_len;
    logic [63:0] tok_word[3];

    // no-gap stretches for both sides, and a one-shot long hold-off request
    logic fast_mode    = 1'b0;
    logic hold_request = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    response_token_matcher_with_capture_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    response_token_matcher_with_capture_unit_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .error_count  (error_count),
        .pending      (pending),
        .items_seen   (items_seen),
        .found_seen   (found_seen),
        .timeout_seen (timeout_seen),
        .capture_seen (capture_seen)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int unsigned token_span();
        if (tok_len == 5'd0) return 1;
        if (tok_len > rtm_pkg::TOKEN_SLOTS) return rtm_pkg::TOKEN_SLOTS;
        return tok_len;
    endfunction

    function automatic logic [7:0] token_at(input int unsigned idx);
        logic [191:0] all_chars;
        all_chars = {tok_word[2], tok_word[1], tok_word[0]};
        return all_chars[idx*8 +: 8];
    endfunction

    // Offer one input transaction after a random gap and hold it until taken.
    // Entered and left just after a falling edge; tvalid stays high on exit so
    // that a back-to-back transaction never lowers and raises it in one step.
    task automatic send_item(input logic [1:0] kind, input logic [7:0] data);
        int unsigned gap;
        gap = fast_mode ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
        @(negedge aclk);
    endtask

    // Drop tvalid, wait until every predicted result has arrived, then let
    // the block finish any work that produces nothing.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write all six registers while the block is idle; upper bits of the
    // narrow registers carry random junk that the block must mask off.
    // Unused indexes go last, so that an alias onto a real register shows.
    task automatic write_settings(input logic [4:0] len, input logic [63:0] low,
                                  input logic [63:0] mid, input logic [63:0] high,
                                  input logic [15:0] ticks, input logic skip,
                                  input logic spare);
        logic [2:0]  idx[8];
        logic [63:0] val[8];
        int unsigned n;
        int unsigned i;
        drain_results();
        idx[0] = rtm_pkg::REG_TOKEN_LENGTH;  val[0] = rand64(); val[0][4:0]  = len;
        idx[1] = rtm_pkg::REG_CHARS_LOW;     val[1] = low;
        idx[2] = rtm_pkg::REG_CHARS_MID;     val[2] = mid;
        idx[3] = rtm_pkg::REG_CHARS_HIGH;    val[3] = high;
        idx[4] = rtm_pkg::REG_TIMEOUT_TICKS; val[4] = rand64(); val[4][15:0] = ticks;
        idx[5] = rtm_pkg::REG_ALWAYS_SKIP;   val[5] = rand64(); val[5][0]    = skip;
        idx[6] = REG_SPARE_LO;               val[6] = rand64();
        idx[7] = REG_SPARE_HI;               val[7] = rand64();
        n = spare ? 8 : 6;
        for (i = 0; i < n; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
        tok_len     = len;
        tok_word[0] = low;
        tok_word[1] = mid;
        tok_word[2] = high;
    endtask

    // One armed search: usually a start, perhaps some leading line breaks, then a
    // few attempts at the token, each either complete or cut short by a
    // wrong byte, with ticks, breaks and junk sprinkled in between.
    task automatic run_search();
        int unsigned span;
        int unsigned prefix;
        int unsigned attempts;
        int unsigned a;
        int unsigned i;
        span = token_span();
        if ($urandom_range(0, 9) != 0) send_item(rtm_pkg::KIND_START, 8'($urandom));
        repeat ($urandom_range(0, 2))
            send_item(rtm_pkg::KIND_BYTE,
                      $urandom_range(0, 1) ? rtm_pkg::CHAR_CR : rtm_pkg::CHAR_LF);
        attempts = $urandom_range(1, 3);
        for (a = 0; a < attempts; a++) begin
            prefix = $urandom_range(0, 1) ? span : $urandom_range(0, span - 1);
            for (i = 0; i < prefix; i++) begin
                case ($urandom_range(0, 29))
                    0, 1:    send_item(rtm_pkg::KIND_TICK, 8'($urandom));
                    2:       send_item(rtm_pkg::KIND_BYTE,
                                       $urandom_range(0, 1) ? rtm_pkg::CHAR_CR
                                                            : rtm_pkg::CHAR_LF);
                    3:       send_item(KIND_SPARE, 8'($urandom));
                    4:       send_item(rtm_pkg::KIND_BYTE, 8'($urandom));
                    default: ;
                endcase
                send_item(rtm_pkg::KIND_BYTE, token_at(i));
            end
            if (prefix < span)
                send_item(rtm_pkg::KIND_BYTE,
                          token_at(prefix) ^ 8'($urandom_range(1, 255)));
        end
    endtask

    // Result side: stall for a random number of cycles before each result,
    // or for a long stretch once when asked, then take the next one.
    initial begin : result_sink
        int unsigned stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_request) begin
                stall        = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                stall = fast_mode ? 0 : $urandom_range(0, 4);
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Give up when no channel has moved a transaction for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("response_token_matcher_with_capture_unit regression: fail");
        $finish;
    end

    initial begin : stimulus
        int unsigned phase;
        int unsigned k;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = rtm_pkg::KIND_START;
        cfg_valid   = 1'b0;
        cfg_index   = rtm_pkg::REG_TOKEN_LENGTH;
        cfg_data    = '0;
        tok_len     = 5'd2;
        tok_word[0] = 64'h4B4F;
        tok_word[1] = '0;
        tok_word[2] = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, reset settings ("OK", two characters).
        // Idle block: bytes, ticks and the unused kind are all ignored.
        send_item(rtm_pkg::KIND_BYTE, CHAR_O);
        send_item(rtm_pkg::KIND_TICK, 8'h00);
        send_item(KIND_SPARE, 8'hFF);
        // leading line breaks are skipped, then a clean match
        send_item(rtm_pkg::KIND_START, 8'h00);
        send_item(rtm_pkg::KIND_BYTE, rtm_pkg::CHAR_LF);
        send_item(rtm_pkg::KIND_BYTE, rtm_pkg::CHAR_CR);
        send_item(rtm_pkg::KIND_BYTE, CHAR_O);
        send_item(rtm_pkg::KIND_BYTE, CHAR_K);
        // a break after the first byte is a mismatch: replay the prefix
        send_item(rtm_pkg::KIND_START, 8'hFF);
        send_item(rtm_pkg::KIND_BYTE, CHAR_O);
        send_item(rtm_pkg::KIND_BYTE, rtm_pkg::CHAR_CR);
        send_item(rtm_pkg::KIND_BYTE, 8'hFF);
        // the offending byte is not retried as a new start
        send_item(rtm_pkg::KIND_BYTE, CHAR_O);
        send_item(rtm_pkg::KIND_BYTE, CHAR_O);
        send_item(rtm_pkg::KIND_BYTE, 8'h00);
        send_item(KIND_SPARE, 8'h00);
        send_item(rtm_pkg::KIND_BYTE, CHAR_O);
        send_item(rtm_pkg::KIND_BYTE, CHAR_K);
        // leave a search open with two ticks gone, then lower the limit down to it
        send_item(rtm_pkg::KIND_START, 8'h00);
        send_item(rtm_pkg::KIND_TICK, 8'h00);
        send_item(rtm_pkg::KIND_TICK, 8'h00);
        write_settings(5'd2, 64'h4B4F, '0, '0, 16'd2, 1'b0, 1'b0);
        send_item(rtm_pkg::KIND_BYTE, CHAR_O);
        send_item(rtm_pkg::KIND_START, 8'h00);
        send_item(rtm_pkg::KIND_TICK, 8'h00);
        send_item(rtm_pkg::KIND_TICK, 8'h00);
        // zero limit: the first byte already finds time run out
        write_settings(5'd2, 64'h4B4F, '0, '0, 16'd0, 1'b0, 1'b0);
        send_item(rtm_pkg::KIND_START, 8'h00);
        send_item(rtm_pkg::KIND_BYTE, CHAR_O);

        // Random part: cycle through settings until enough inputs have been
        // sent, and at least once through every setting.
        phase = 0;
        while (sent_count < TARGET_ITEMS || phase < 6) begin
            case (phase % 6)
                0: write_settings(5'd24, rand64(), rand64(), rand64(), 16'hFFFF, 1'b1, 1'b0);
                1: write_settings(5'd0, '1, '0, '0, 16'd8, 1'b0, 1'b1);
                2: write_settings(5'd31, rand64(), rand64(), rand64(),
                                  16'($urandom_range(30, 200)), 1'b0, 1'b0);
                3: write_settings(5'($urandom_range(2, 12)), rand64(), rand64(), rand64(),
                                  16'd0, 1'($urandom), 1'b0);
                4: write_settings(5'($urandom_range(1, 24)), rand64(), rand64(), rand64(),
                                  16'($urandom_range(3, 60)), 1'b1, 1'b1);
                default: write_settings(5'($urandom_range(1, 24)), rand64(), rand64(),
                                        rand64(), 16'($urandom), 1'($urandom), 1'b0);
            endcase
            fast_mode = (phase % 4 == 3);
            for (k = 0; k < 3 && (sent_count < TARGET_ITEMS || k == 0); k++) begin
                // long receiver hold-off while replies with long replays keep coming
                if (phase == 2 && k == 0) hold_request = 1'b1;
                // pause the sender until everything outstanding has come out
                if (phase % 2 == 1 && k == 2) drain_results();
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 4))
                        send_item(2'($urandom_range(0, 3)), 8'($urandom));
                else
                    run_search();
            end
            phase++;
        end
        fast_mode = 1'b0;

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        $display("covered %0d register settings and %0d input transactions, %0d acted on",
                 phase + 3, sent_count, items_seen);
        $display("results checked: %0d found, %0d timed out, %0d captured bytes",
                 found_seen, timeout_seen, capture_seen);
        if (error_count == 0)
            $display("response_token_matcher_with_capture_unit regression: pass");
        else
            $display("response_token_matcher_with_capture_unit regression: fail");
        $finish;
    end

endmodule
